FILE: rtl/fpvt_pkg.sv
`default_nettype none

package fpvt_pkg;

  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned CNT_W    = 4;
  localparam int unsigned CFG_AW   = 3;
  localparam int unsigned CFG_DW   = 4;

  localparam logic [CFG_AW-1:0] REG_WIDTH_CODE = 3'd0;
  localparam logic [CFG_AW-1:0] REG_SIGNED     = 3'd1;
  localparam logic [CFG_AW-1:0] REG_HEX        = 3'd2;
  localparam logic [CFG_AW-1:0] REG_DIGITS     = 3'd3;
  localparam logic [CFG_AW-1:0] REG_FRACTION   = 3'd4;

  localparam logic [1:0] WIDTH_8  = 2'd0;
  localparam logic [1:0] WIDTH_16 = 2'd1;

  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_HEX   = 8'h37;  // 'A' - 10
  localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_POINT = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

  localparam logic [3:0]  RADIX_DEC  = 4'd10;
  localparam logic [3:0]  HEX_MASK   = 4'hF;
  localparam logic [63:0] RECIP_TEN  = 64'h0000_0000_CCCC_CCCD;  // ceil(2^35 / 10)

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } state_e;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d);
    if (d < RADIX_DEC) begin
      return CH_ZERO + {4'd0, d};
    end
    return CH_HEX + {4'd0, d};
  endfunction

endpackage

`default_nettype wire

FILE: rtl/fixed_point_value_to_text.sv
// Flow: the value is registered when taken, then its digits come in turn from the
//   shared divide-by-ten / nibble-shift unit (not for the all-star field), then one
//   character per cycle while m_axis_tready allows. The single digit unit and the
//   one-character output register serve it; no new value is taken until done.
// Reset (rst_ni low, asynchronous): registers return to 32-bit, unsigned, decimal,
//   10 digits, no point; the sequencer goes idle and the output holds no beat.
`default_nettype none

module fixed_point_value_to_text #(
  parameter int unsigned MAX_DIGITS      = 10,
  parameter int unsigned MAX_FIELD_CHARS = 12
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // config write channel
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [fpvt_pkg::CFG_AW-1:0]   cfg_index_i,
  input  wire logic [fpvt_pkg::CFG_DW-1:0]   cfg_data_i,
  // input stream
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [fpvt_pkg::VALUE_W-1:0]  s_axis_tdata,   // [31:0] raw_value
  // output stream
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic [fpvt_pkg::CHAR_W-1:0]        m_axis_tdata,   // [7:0] text_char
  output logic                               m_axis_tlast    // last_char
);

  localparam int unsigned CW     = fpvt_pkg::CNT_W;
  localparam int unsigned BUF_AW = (MAX_FIELD_CHARS > 1) ? $clog2(MAX_FIELD_CHARS) : 1;
  localparam logic [CW-1:0] MAX_DIG_C   = CW'(MAX_DIGITS);
  localparam logic [CW-1:0] MAX_FIELD_C = CW'(MAX_FIELD_CHARS);

  // configuration registers
  logic [1:0]    width_code_q;
  logic          signed_q;
  logic          hex_q;
  logic [CW-1:0] digits_q;
  logic [CW-1:0] frac_q;

  // sequencer and datapath registers
  fpvt_pkg::state_e state_q, state_d;
  logic [fpvt_pkg::VALUE_W-1:0] work_q, work_d;
  logic [CW-1:0] step_q, step_d;
  logic [CW-1:0] run_q, run_d;
  logic [CW-1:0] pos_q, pos_d;
  logic          star_q, star_d;
  logic [fpvt_pkg::CHAR_W-1:0] sign_q, sign_d;
  logic          out_valid_q, out_valid_d;
  logic [fpvt_pkg::CHAR_W-1:0] out_char_q, out_char_d;
  logic          out_last_q, out_last_d;
  logic [fpvt_pkg::CHAR_W-1:0] buf_q [MAX_FIELD_CHARS];

  // field geometry from configuration
  logic [CW-1:0] cap, dc, len, idig, fd_eff, point_pos, blank_max, blank_cnt;
  logic          has_point;

  always_comb begin
    cap = MAX_FIELD_C - CW'(1) - CW'(signed_q);
    dc  = (digits_q == '0) ? CW'(1) : digits_q;
    if (dc > MAX_DIG_C) begin
      dc = MAX_DIG_C;
    end
    if (dc > cap) begin
      dc = cap;
    end
    if (dc == '0) begin
      dc = CW'(1);
    end
    has_point = (frac_q != '0) && (frac_q < dc);
    fd_eff    = has_point ? frac_q : '0;
    len       = dc + CW'(has_point) + CW'(signed_q);
    point_pos = len - CW'(1) - frac_q;
    idig      = dc - fd_eff;
    blank_max = idig - CW'(1);
    blank_cnt = (run_q < blank_max) ? run_q : blank_max;
  end

  // input value preparation
  logic [fpvt_pkg::VALUE_W-1:0] mask, raw_m, sign_bit, mag;
  logic is_neg;

  always_comb begin
    case (width_code_q)
      fpvt_pkg::WIDTH_8:  mask = 32'h0000_00FF;
      fpvt_pkg::WIDTH_16: mask = 32'h0000_FFFF;
      default:            mask = 32'hFFFF_FFFF;
    endcase
    sign_bit = (mask >> 1) + 32'd1;
    raw_m    = s_axis_tdata & mask;
    is_neg   = signed_q && ((raw_m & sign_bit) != '0);
    mag      = ((~raw_m) + 32'd1) & mask;
  end

  // shared digit unit: divide by ten through a reciprocal, or take a nibble
  logic [63:0] prod;
  logic [31:0] quot, rem;
  logic [3:0]  digit;
  logic [fpvt_pkg::VALUE_W-1:0] work_next;

  always_comb begin
    prod = {32'd0, work_q} * fpvt_pkg::RECIP_TEN;
    quot = {3'd0, prod[63:35]};
    rem  = work_q - ((quot << 3) + (quot << 1));
    if (hex_q) begin
      digit     = work_q[3:0] & fpvt_pkg::HEX_MASK;
      work_next = work_q >> 4;
    end else begin
      digit     = rem[3:0];
      work_next = quot;
    end
  end

  logic [CW-1:0] wr_pos;
  assign wr_pos = len - CW'(1) - step_q - CW'(has_point && (step_q >= frac_q));

  // character at the current output position
  logic [fpvt_pkg::CHAR_W-1:0] emit_char;
  always_comb begin
    if (star_q) begin
      emit_char = fpvt_pkg::CH_STAR;
    end else if (signed_q && (pos_q < blank_cnt)) begin
      emit_char = fpvt_pkg::CH_SPACE;
    end else if (signed_q && (pos_q == blank_cnt)) begin
      emit_char = sign_q;
    end else if (has_point && (pos_q == point_pos)) begin
      emit_char = fpvt_pkg::CH_POINT;
    end else begin
      emit_char = buf_q[pos_q[BUF_AW-1:0]];
    end
  end

  logic out_free;
  assign out_free = !out_valid_q || m_axis_tready;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      fpvt_pkg::ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = (is_neg && (raw_m == sign_bit)) ? fpvt_pkg::ST_EMIT : fpvt_pkg::ST_CONV;
        end
      end
      fpvt_pkg::ST_CONV: begin
        if (step_q == dc - CW'(1)) begin
          state_d = fpvt_pkg::ST_EMIT;
        end
      end
      fpvt_pkg::ST_EMIT: begin
        if (out_free && (pos_q == len - CW'(1))) begin
          state_d = fpvt_pkg::ST_IDLE;
        end
      end
      default: state_d = fpvt_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    work_d      = work_q;
    step_d      = step_q;
    run_d       = run_q;
    pos_d       = pos_q;
    star_d      = star_q;
    sign_d      = sign_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    s_axis_tready = 1'b0;
    case (state_q)
      fpvt_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          work_d = is_neg ? mag : raw_m;
          star_d = is_neg && (raw_m == sign_bit);
          sign_d = is_neg ? fpvt_pkg::CH_MINUS : fpvt_pkg::CH_SPACE;
          step_d = '0;
          run_d  = '0;
          pos_d  = '0;
        end
      end
      fpvt_pkg::ST_CONV: begin
        work_d = work_next;
        step_d = step_q + CW'(1);
        if (step_q >= fd_eff) begin
          run_d = (digit == 4'd0) ? run_q + CW'(1) : '0;
        end
      end
      fpvt_pkg::ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_char_d  = emit_char;
          out_last_d  = (pos_q == len - CW'(1));
          pos_d       = pos_q + CW'(1);
        end
      end
      default: ;
    endcase
  end

  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_char_q;
  assign m_axis_tlast  = out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_code_q <= 2'd2;
      signed_q     <= 1'b0;
      hex_q        <= 1'b0;
      digits_q     <= CW'(10);
      frac_q       <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        fpvt_pkg::REG_WIDTH_CODE: width_code_q <= cfg_data_i[1:0];
        fpvt_pkg::REG_SIGNED:     signed_q     <= cfg_data_i[0];
        fpvt_pkg::REG_HEX:        hex_q        <= cfg_data_i[0];
        fpvt_pkg::REG_DIGITS:     digits_q     <= cfg_data_i;
        fpvt_pkg::REG_FRACTION:   frac_q       <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fpvt_pkg::ST_IDLE;
      work_q      <= '0;
      step_q      <= '0;
      run_q       <= '0;
      pos_q       <= '0;
      star_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      work_q      <= work_d;
      step_q      <= step_d;
      run_q       <= run_d;
      pos_q       <= pos_d;
      star_q      <= star_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sign_q     <= sign_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
    if (state_q == fpvt_pkg::ST_CONV) begin
      buf_q[wr_pos[BUF_AW-1:0]] <= fpvt_pkg::digit_char(digit);
    end
  end

  // a new value is never taken back to back
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken while busy");

  a_conv_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == fpvt_pkg::ST_CONV) |-> (step_q < dc))
    else $error("digit step beyond digit count");

  a_emit_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == fpvt_pkg::ST_EMIT) |-> (pos_q < len))
    else $error("emit position beyond field");

  a_last_ends_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == fpvt_pkg::ST_EMIT) && out_free && (pos_q == len - CW'(1)))
      |=> (state_q == fpvt_pkg::ST_IDLE) && m_axis_tlast && m_axis_tvalid)
    else $error("final character not flagged");

endmodule

`default_nettype wire

FILE: tb/fpvt_text_checker.sv
`timescale 1ns / 1ps

module fpvt_text_checker #(
  parameter int unsigned MAX_DIGITS      = 10,
  parameter int unsigned MAX_FIELD_CHARS = 12,
  parameter logic [1:0]  RESET_WIDTH     = 2'd2
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [fpvt_pkg::CFG_AW-1:0]   cfg_index_i,
  input  logic [fpvt_pkg::CFG_DW-1:0]   cfg_data_i,
  input  logic                          value_valid_i,
  input  logic                          value_ready_i,
  input  logic [fpvt_pkg::VALUE_W-1:0]  value_data_i,   // [31:0] raw_value
  input  logic                          text_valid_i,
  input  logic                          text_ready_i,
  input  logic [fpvt_pkg::CHAR_W-1:0]   text_data_i,    // [7:0] text_char
  input  logic                          text_last_i,
  output int unsigned                   fail_count_o,
  output int unsigned                   pending_o
);

  typedef struct packed {
    logic [fpvt_pkg::CHAR_W-1:0] code;
    logic                        last;
  } text_beat_t;

  text_beat_t  expected_chars[$];
  logic [1:0]  width_code;
  logic        signed_en;
  logic        hex_en;
  logic [3:0]  digit_cfg;
  logic [3:0]  frac_cfg;
  int unsigned mismatches;

  // Build the expected text field for one value and queue it, leftmost char first.
  function automatic void format_field(input logic [fpvt_pkg::VALUE_W-1:0] raw_in);
    logic [fpvt_pkg::CHAR_W-1:0]  field [MAX_FIELD_CHARS];
    logic [fpvt_pkg::VALUE_W-1:0] mask;
    logic [fpvt_pkg::VALUE_W-1:0] signbit;
    logic [fpvt_pkg::VALUE_W-1:0] raw;
    logic [fpvt_pkg::VALUE_W-1:0] mag;
    logic [3:0]                   nib;
    logic                         has_point;
    logic                         all_stars;
    int unsigned                  nbits;
    int unsigned                  dc;
    int unsigned                  len;
    int unsigned                  pointpos;
    int unsigned                  extra;
    int unsigned                  i;
    text_beat_t                   beat;

    nbits = (width_code == fpvt_pkg::WIDTH_8) ? 8 :
            (width_code == fpvt_pkg::WIDTH_16) ? 16 : 32;
    mask  = (nbits == 32) ? {fpvt_pkg::VALUE_W{1'b1}} : ((32'd1 << nbits) - 32'd1);

    dc = (digit_cfg == 0) ? 1 : digit_cfg;
    if (dc > MAX_DIGITS) dc = MAX_DIGITS;
    if (dc > MAX_FIELD_CHARS - 1 - signed_en) dc = MAX_FIELD_CHARS - 1 - signed_en;
    if (dc == 0) dc = 1;
    has_point = (frac_cfg != 0) && (frac_cfg < dc);
    len       = dc + has_point + signed_en;
    pointpos  = len;
    all_stars = 1'b0;

    raw     = raw_in & mask;
    mag     = raw;
    signbit = 32'd1 << (nbits - 1);
    if (signed_en) begin
      if ((raw & signbit) != 0) begin
        if (raw == signbit) begin
          all_stars = 1'b1;
        end else begin
          mag      = (~raw + 32'd1) & mask;
          field[0] = fpvt_pkg::CH_MINUS;
        end
      end else begin
        field[0] = fpvt_pkg::CH_SPACE;
      end
    end

    if (all_stars) begin
      for (i = 0; i < len; i++) field[i] = fpvt_pkg::CH_STAR;
    end else begin
      extra = 0;
      for (i = 0; i < dc; i++) begin
        if (has_point && i == frac_cfg) begin
          pointpos        = len - 1 - i;
          field[pointpos] = fpvt_pkg::CH_POINT;
          extra           = 1;
        end
        if (hex_en) begin
          nib = mag[3:0];
          mag = mag >> 4;
        end else begin
          nib = 4'(mag % fpvt_pkg::RADIX_DEC);
          mag = mag / fpvt_pkg::RADIX_DEC;
        end
        field[len - 1 - i - extra] = (nib < fpvt_pkg::RADIX_DEC) ?
                                     fpvt_pkg::CH_ZERO + {4'd0, nib} :
                                     fpvt_pkg::CH_HEX + {4'd0, nib};
      end
      // in a signed field, blank leading zeros and slide the sign right, stop before the point
      if (signed_en) begin
        for (i = 1; i + 1 < len; i++) begin
          if (field[i] != fpvt_pkg::CH_ZERO || pointpos == i + 1) break;
          field[i]     = field[i - 1];
          field[i - 1] = fpvt_pkg::CH_SPACE;
        end
      end
    end

    for (i = 0; i < len; i++) begin
      beat.code = field[i];
      beat.last = (i == len - 1);
      expected_chars.push_back(beat);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    text_beat_t want;
    if (!rst_ni) begin
      width_code = RESET_WIDTH;
      signed_en  = 1'b0;
      hex_en     = 1'b0;
      digit_cfg  = 4'(MAX_DIGITS);
      frac_cfg   = 4'd0;
      mismatches = 0;
      expected_chars.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          fpvt_pkg::REG_WIDTH_CODE: width_code = cfg_data_i[1:0];
          fpvt_pkg::REG_SIGNED:     signed_en  = cfg_data_i[0];
          fpvt_pkg::REG_HEX:        hex_en     = cfg_data_i[0];
          fpvt_pkg::REG_DIGITS:     digit_cfg  = cfg_data_i;
          fpvt_pkg::REG_FRACTION:   frac_cfg   = cfg_data_i;
          default: ;
        endcase
      end
      // drain the older field before queuing a new one
      if (text_valid_i && text_ready_i) begin
        if (expected_chars.size() == 0) begin
          mismatches++;
          $display("%0t: char %h last %b with no field pending", $time, text_data_i,
                   text_last_i);
        end else begin
          want = expected_chars.pop_front();
          if (want.code != text_data_i) begin
            mismatches++;
            $display("%0t: text_char expected %h actual %h", $time, want.code, text_data_i);
          end
          if (want.last != text_last_i) begin
            mismatches++;
            $display("%0t: last_char expected %b actual %b", $time, want.last, text_last_i);
          end
        end
      end
      if (value_valid_i && value_ready_i) format_field(value_data_i);
      fail_count_o <= mismatches;
      pending_o    <= expected_chars.size();
    end
  end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned     CYCLE_LIMIT = 200000;
  localparam logic [1:0]      WIDTH_32    = 2'd2;
  localparam logic [1:0]      WIDTH_WIDE  = 2'd3;
  localparam logic [fpvt_pkg::CFG_AW-1:0] REG_UNUSED = 3'd7;

  logic                          clk_i         = 1'b0;
  logic                          rst_ni        = 1'b0;
  logic                          cfg_valid_i   = 1'b0;
  logic                          cfg_ready_o;
  logic [fpvt_pkg::CFG_AW-1:0]   cfg_index_i   = '0;
  logic [fpvt_pkg::CFG_DW-1:0]   cfg_data_i    = '0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [fpvt_pkg::VALUE_W-1:0]  s_axis_tdata  = '0;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [fpvt_pkg::CHAR_W-1:0]   m_axis_tdata;
  logic                          m_axis_tlast;

  int unsigned fail_count;
  int unsigned pending_chars;
  int unsigned cycle_count = 0;
  int unsigned phase_idx   = 0;
  int unsigned gap_pct     = 0;
  int unsigned stall_pct   = 0;

  fixed_point_value_to_text dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  fpvt_text_checker #(
    .RESET_WIDTH (WIDTH_32)
  ) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .value_valid_i (s_axis_tvalid),
    .value_ready_i (s_axis_tready),
    .value_data_i  (s_axis_tdata),
    .text_valid_i  (m_axis_tvalid),
    .text_ready_i  (m_axis_tready),
    .text_data_i   (m_axis_tdata),
    .text_last_i   (m_axis_tlast),
    .fail_count_o  (fail_count),
    .pending_o     (pending_chars)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic cfg_write(input logic [fpvt_pkg::CFG_AW-1:0] idx,
                           input logic [fpvt_pkg::CFG_DW-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic cfg_close();
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Drop valid and hold until every queued char has come out.
  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_chars != 0) @(negedge clk_i);
  endtask

  task automatic apply_settings(input logic [1:0] width, input logic sgn, input logic hex,
                                input logic [3:0] digits, input logic [3:0] frac);
    settle();
    cfg_write(fpvt_pkg::REG_WIDTH_CODE, {2'b00, width});
    cfg_write(fpvt_pkg::REG_SIGNED, {3'b000, sgn});
    cfg_write(fpvt_pkg::REG_HEX, {3'b000, hex});
    cfg_write(fpvt_pkg::REG_DIGITS, digits);
    cfg_write(fpvt_pkg::REG_FRACTION, frac);
    cfg_close();
    case (phase_idx % 4)
      0:       begin gap_pct = 0;  stall_pct = 0;  end
      1:       begin gap_pct = 50; stall_pct = 0;  end
      2:       begin gap_pct = 0;  stall_pct = 50; end
      default: begin gap_pct = 6;  stall_pct = 6;  end
    endcase
    phase_idx++;
  endtask

  task automatic send_value(input logic [fpvt_pkg::VALUE_W-1:0] value);
    @(negedge clk_i);
    while ($urandom_range(99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  initial begin
    logic [fpvt_pkg::VALUE_W-1:0] value;
    logic [3:0]                   digits;
    int                           phase;
    int                           n;

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // an index past the register list must leave the settings alone
    cfg_write(REG_UNUSED, 4'hF);
    cfg_close();

    // reset settings: 32-bit unsigned decimal, ten digits, no point
    send_value(32'h0000_0000);
    send_value(32'hFFFF_FFFF);
    send_value(32'd1234567890);

    apply_settings(WIDTH_32, 1'b1, 1'b0, 4'd10, 4'd0);
    send_value(32'h8000_0000);
    send_value(32'h7FFF_FFFF);
    send_value(32'hFFFF_FFFF);
    send_value(32'h0000_0000);

    apply_settings(fpvt_pkg::WIDTH_8, 1'b1, 1'b1, 4'd3, 4'd1);
    send_value(32'h0000_0080);
    send_value(32'h0000_007F);
    send_value(32'h0000_0081);
    send_value(32'hFFFF_FF05);

    // width code three and an oversized digit count saturate
    apply_settings(WIDTH_WIDE, 1'b0, 1'b1, 4'd15, 4'd15);
    send_value(32'hDEAD_BEEF);
    send_value(32'hFFFF_FFFF);

    apply_settings(fpvt_pkg::WIDTH_16, 1'b1, 1'b0, 4'd0, 4'd0);
    send_value(32'h0000_8000);
    send_value(32'h0000_0005);

    apply_settings(fpvt_pkg::WIDTH_16, 1'b1, 1'b0, 4'd5, 4'd2);
    send_value(32'h0000_FFFF);
    send_value(32'h0000_0007);
    send_value(32'h0000_FF9C);
    send_value(32'd12345);

    apply_settings(fpvt_pkg::WIDTH_8, 1'b0, 1'b0, 4'd10, 4'd9);
    send_value(32'h0000_00FF);
    send_value(32'h0000_0000);

    apply_settings(WIDTH_32, 1'b1, 1'b0, 4'd11, 4'd5);
    send_value(32'h8000_0001);
    send_value(32'd100);

    for (phase = 0; phase < 24; phase++) begin
      digits = ($urandom_range(7) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(10, 1));
      apply_settings(2'($urandom_range(3)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                     digits,
                     ($urandom_range(4) == 0) ? 4'($urandom_range(15))
                                              : 4'($urandom_range(digits)));
      for (n = 0; n < 14; n++) begin
        case ($urandom_range(5))
          0:       value = $urandom();
          1:       value = $urandom_range(20);
          2:       value = 32'd0 - $urandom_range(20);
          // around the sign bit of each operand width
          3:       value = (32'd1 << (8 * (1 << $urandom_range(2)) - 1))
                           + $urandom_range(2) - 32'd1;
          4:       value = $urandom_range(99999);
          default: value = $urandom() >> $urandom_range(31);
        endcase
        send_value(value);
      end
    end

    settle();
    repeat (40) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
